FILE: sv/ccb_pkg.sv
// ----------------------------------------------------------------------------
// ccb_pkg
// Types and constants shared by the camera control bus frame transceiver.
// ----------------------------------------------------------------------------
package ccb_pkg;

   // Operation codes carried with each input beat.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // First command byte inserted by a load.
   localparam logic [7:0] CMD_FIRST_BYTE = 8'h28;

   // Width of the command word held for transmission.
   localparam int CMD_BITS = 16;

   // Register indexes on the control port (word address bit 2).
   localparam logic CSR_BIT_TICKS = 1'b0;
   localparam logic CSR_SYNC_GAP  = 1'b1;

   // Reset values of the registers.
   localparam logic [11:0] BIT_TICKS_RESET = 12'd104;
   localparam logic [15:0] SYNC_GAP_RESET  = 16'd3000;

   typedef enum logic [2:0] {
      PH_SEARCH     = 3'd0,
      PH_WAIT_START = 3'd1,
      PH_TX_BIT     = 3'd2,
      PH_TX_STOP    = 3'd3,
      PH_WAIT_NEXT  = 3'd4,
      PH_RX_BIT     = 3'd5
   } phase_type;

   typedef struct packed {
      logic [11:0] bit_ticks;
      logic [15:0] sync_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       line_level;
      logic [7:0] command_data;
   } req_type;

   typedef struct packed {
      logic       drive_level;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [2:0] rx_index;
      logic       frame_done;
   } rsp_type;

endpackage

FILE: sv/ccb_engine.sv
// ----------------------------------------------------------------------------
// ccb_engine
// Frame state machine and bit timing: one accepted tick beat advances it by one
// tick and yields the result of that tick; a load or clear beat only sets the pending command.
// ----------------------------------------------------------------------------
module ccb_engine #(
   parameter int FRAME_BYTES = 8,
   parameter int TX_BYTES    = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_en,
   input  ccb_pkg::req_type req,
   input  ccb_pkg::cfg_type cfg,
   output ccb_pkg::rsp_type rsp
);
   import ccb_pkg::*;

   localparam int MAX_BYTES  = (FRAME_BYTES > TX_BYTES) ? FRAME_BYTES : TX_BYTES;
   localparam int BIT_W      = $clog2(MAX_BYTES * 8 + 1);
   localparam logic [BIT_W-1:0] FRAME_BITS = BIT_W'(FRAME_BYTES * 8);
   localparam logic [BIT_W-1:0] TX_BITS    = BIT_W'(TX_BYTES * 8);
   localparam logic [BIT_W-1:0] CMD_LIMIT  = BIT_W'(CMD_BITS);

   phase_type        phase_ff, phase_in;
   logic [15:0]      elapsed_ff, elapsed_in;
   logic [BIT_W-1:0] bit_index_ff, bit_index_in;
   logic [15:0]      active_ff, active_in;
   logic [15:0]      pending_ff, pending_in;
   logic             swap_ff, swap_in;
   logic             drive_ff, drive_in;
   logic [7:0]       rx_shift_ff, rx_shift_in;

   logic             tick;
   logic [15:0]      elapsed_inc;
   logic [15:0]      gap_count;
   logic [2:0]       bitn;
   logic [BIT_W+2:0] bit_ext;
   logic [BIT_W-1:0] bit_inc;
   logic [15:0]      tx_thr;
   logic [16:0]      rx_thr;
   logic [15:0]      stop_thr;
   logic [16:0]      next_thr;
   logic [10:0]      half_bit;
   logic             gap_hit, tx_hit, rx_hit, stop_hit, next_hit;
   logic             tx_bit;
   logic [7:0]       rx_shift_new;

   assign tick        = item_en && (req.operation == OP_TICK);
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign gap_count   = req.line_level ? elapsed_inc : 16'd0;
   assign bitn        = bit_index_ff[2:0];
   assign bit_ext     = {3'b000, bit_index_ff};
   assign bit_inc     = bit_index_ff + BIT_W'(1);
   assign half_bit    = cfg.bit_ticks[11:1];

   // Bit thresholds measured from the start bit of the current byte.
   assign tx_thr   = 16'({1'b0, bitn} + 4'd1) * 16'(cfg.bit_ticks);
   assign rx_thr   = 17'(tx_thr) + 17'(half_bit);
   assign stop_thr = 16'(cfg.bit_ticks) * 16'd9;
   assign next_thr = 17'(cfg.bit_ticks) * 17'd10 - 17'(half_bit);

   assign gap_hit  = gap_count >= cfg.sync_gap_ticks;
   assign tx_hit   = elapsed_inc >= tx_thr;
   assign rx_hit   = 17'(elapsed_inc) >= rx_thr;
   assign stop_hit = elapsed_inc >= stop_thr;
   assign next_hit = (17'(elapsed_inc) > next_thr) && !req.line_level;

   // Command bits beyond the command word are driven low.
   assign tx_bit = (bit_index_ff < CMD_LIMIT) ? active_ff[bit_index_ff[3:0]] : 1'b0;

   always_comb begin
      rx_shift_new       = rx_shift_ff;
      rx_shift_new[bitn] = req.line_level;
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (tick) begin
         case (phase_ff)
            PH_SEARCH: begin
               if (gap_hit) phase_in = PH_WAIT_START;
            end
            PH_WAIT_START: begin
               if (!req.line_level) phase_in = PH_TX_BIT;
            end
            PH_TX_BIT: begin
               if (tx_hit && bitn == 3'd7) phase_in = PH_TX_STOP;
            end
            PH_TX_STOP: begin
               if (stop_hit) begin
                  phase_in = (bit_index_ff >= FRAME_BITS) ? PH_SEARCH : PH_WAIT_NEXT;
               end
            end
            PH_WAIT_NEXT: begin
               if (next_hit) phase_in = (bit_index_ff >= TX_BITS) ? PH_RX_BIT : PH_TX_BIT;
            end
            PH_RX_BIT: begin
               if (rx_hit && bitn == 3'd7) begin
                  phase_in = (bit_inc >= FRAME_BITS) ? PH_SEARCH : PH_WAIT_NEXT;
               end
            end
            default: phase_in = PH_SEARCH;
         endcase
      end
   end

   // Datapath and result.
   always_comb begin
      elapsed_in   = elapsed_ff;
      bit_index_in = bit_index_ff;
      active_in    = active_ff;
      pending_in   = pending_ff;
      swap_in      = swap_ff;
      drive_in     = drive_ff;
      rx_shift_in  = rx_shift_ff;
      rsp          = '0;
      if (item_en) begin
         case (req.operation)
            OP_LOAD: begin
               pending_in = {req.command_data, CMD_FIRST_BYTE};
               swap_in    = 1'b1;
            end
            OP_CLEAR: begin
               pending_in = '0;
               swap_in    = 1'b1;
            end
            OP_TICK: begin
               elapsed_in = elapsed_inc;
               case (phase_ff)
                  PH_SEARCH: begin
                     elapsed_in = gap_count;
                  end
                  PH_WAIT_START: begin
                     if (!req.line_level) begin
                        bit_index_in = '0;
                        elapsed_in   = '0;
                     end
                  end
                  PH_TX_BIT: begin
                     if (tx_hit) begin
                        drive_in     = tx_bit;
                        bit_index_in = bit_inc;
                     end
                  end
                  PH_TX_STOP: begin
                     if (stop_hit) begin
                        drive_in = 1'b0;
                        if (bit_index_ff >= FRAME_BITS) begin
                           rsp.frame_done = 1'b1;
                           if (swap_ff) begin
                              active_in = pending_ff;
                              swap_in   = 1'b0;
                           end
                        end
                     end
                  end
                  PH_WAIT_NEXT: begin
                     if (next_hit) elapsed_in = '0;
                  end
                  PH_RX_BIT: begin
                     if (rx_hit) begin
                        rx_shift_in  = rx_shift_new;
                        bit_index_in = bit_inc;
                        if (bitn == 3'd7) begin
                           rsp.rx_valid = 1'b1;
                           rsp.rx_byte  = rx_shift_new;
                           rsp.rx_index = bit_ext[5:3];
                           if (bit_inc >= FRAME_BITS) begin
                              rsp.frame_done = 1'b1;
                              if (swap_ff) begin
                                 active_in = pending_ff;
                                 swap_in   = 1'b0;
                              end
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      rsp.drive_level = drive_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         elapsed_ff   <= '0;
         bit_index_ff <= '0;
         active_ff    <= '0;
         pending_ff   <= '0;
         swap_ff      <= 1'b0;
         drive_ff     <= 1'b0;
         rx_shift_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         bit_index_ff <= bit_index_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         swap_ff      <= swap_in;
         drive_ff     <= drive_in;
         rx_shift_ff  <= rx_shift_in;
      end
   end

endmodule

FILE: sv/camera_control_bus_frame_transceiver.sv
// ----------------------------------------------------------------------------
// camera_control_bus_frame_transceiver
// Ticked transceiver for an eight-byte half-duplex camera control frame.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Beat contents
// req_*     in         one tick (sampled line level) or a command load/clear
// rsp_*     out        drive level, received byte with its position, frame end
// csr_*     in/out     bit period and idle gap length, APB-style
//
// Every input beat yields exactly one response beat, in the cycle after it is
// accepted. A new beat is accepted in every cycle while the response register
// is empty or being drained, so the sustained rate is one tick per cycle; the
// single response register is what couples the two sides.
// Reset is synchronous and active high and returns the block to the idle-gap
// search with an empty command and the register defaults (104 and 3000).
// A stall on the response side only delays further ticks; no beat is lost.
//
// The block waits for a continuous high line of sync_gap_ticks, then follows
// the start bit of each byte. During the first TX_BYTES bytes it drives the
// active command LSB first, one bit at each whole multiple of the bit period;
// during the remaining bytes it samples the line at mid-bit. A loaded command
// is held pending and takes effect at the end of the current frame.
// ----------------------------------------------------------------------------
module camera_control_bus_frame_transceiver #(
   parameter int FRAME_BYTES = 8,
   parameter int TX_BYTES    = 2
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] line_level, [8:1] command_data
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] drive_level, [8:1] rx_byte, [11:9] rx_index
   output logic        rsp_tuser,   // [0] rx_valid
   output logic        rsp_tlast,   // frame_done
   // Control registers.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ccb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   req_type req;
   rsp_type rsp_next;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;
   logic    csr_write;

   // Register file. A write lands on the access cycle; the register is
   // selected by word address bit 2.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_BIT_TICKS: cfg_in.bit_ticks      = csr_pwdata[11:0];
            CSR_SYNC_GAP:  cfg_in.sync_gap_ticks = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_BIT_TICKS: csr_prdata = {20'd0, cfg_ff.bit_ticks};
         CSR_SYNC_GAP:  csr_prdata = {16'd0, cfg_ff.sync_gap_ticks};
         default:       csr_prdata = '0;
      endcase
   end

   // Input beat unpacking.
   assign req.operation    = req_tuser;
   assign req.line_level   = req_tdata[0];
   assign req.command_data = req_tdata[8:1];

   // The response register frees up in the same cycle it is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ccb_engine #(
      .FRAME_BYTES (FRAME_BYTES),
      .TX_BYTES    (TX_BYTES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .item_en (accept),
      .req     (req),
      .cfg     (cfg_ff),
      .rsp     (rsp_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks      <= BIT_TICKS_RESET;
         cfg_ff.sync_gap_ticks <= SYNC_GAP_RESET;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.rx_index, rsp_ff.rx_byte, rsp_ff.drive_level};
   assign rsp_tuser  = rsp_ff.rx_valid;
   assign rsp_tlast  = rsp_ff.frame_done;

endmodule
